@@ hdl/rpn_stack_calculator_assert.svh @@
// Assertion macros for the stack calculator.
// Define NO_ASSERTIONS to compile them out.
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define RPNC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define RPNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RPNC_ASSERT_IMP(lbl, ante, cons, msg)

`define RPNC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/rpnc_pkg.sv @@
`timescale 1ns / 1ps

package rpnc_pkg;

  localparam int unsigned RPNC_STACK_DEPTH = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DEPTH_W  = 5;
  localparam int unsigned DIV_CW   = $clog2(DATA_W);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH,
    FUNC_DROP,
    FUNC_ADD,
    FUNC_SUB,
    FUNC_MUL,
    FUNC_DIV,
    FUNC_MIN,
    FUNC_NONE
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_FEW,
    ST_DIVZ,
    ST_FULL
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DROP_RD,
    S_OP_RD,
    S_DIV,
    S_DIV_FIX,
    S_WB,
    S_MIN_RD,
    S_MIN_CMP,
    S_MIN_WR,
    S_RESP
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_SECOND,
    RD_SCAN
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PUSH,
    WR_BACK,
    WR_MIN
  } wr_sel_e;

  typedef enum logic [1:0] {
    TOP_HOLD,
    TOP_OPND,
    TOP_RDATA,
    TOP_ACC
  } top_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_ARITH,
    ACC_TOP,
    ACC_MIN,
    ACC_DIV_FIX
  } acc_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     latch_in;
    rd_sel_e  rd_sel;
    wr_sel_e  wr_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    top_sel_e top_sel;
    acc_sel_e acc_sel;
    logic     div_start;
    logic     div_step;
    logic     scan_clr;
    logic     scan_inc;
    logic     status_set;
    status_e  status;
    logic     out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_e func;
    logic  cnt_zero;
    logic  cnt_one;
    logic  cnt_lt2;
    logic  cnt_full;
    logic  top_zero;
    logic  div_last;
    logic  scan_last;
  } stat_t;

endpackage

@@ hdl/rpnc_if.sv @@
`timescale 1ns / 1ps

interface rpnc_cmd_if;
  import rpnc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] operand;

  modport source (output valid, output func, output operand, input ready);
  modport sink   (input valid, input func, input operand, output ready);
endinterface

interface rpnc_rsp_if;
  import rpnc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_W-1:0]       depth;

  modport source (output valid, output status, output top_value, output depth, input ready);
  modport sink   (input valid, input status, input top_value, input depth, output ready);
endinterface

@@ hdl/rpnc_ctrl.sv @@
`timescale 1ns / 1ps

module rpnc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  rpnc_pkg::stat_t stat_i,
  output rpnc_pkg::cmd_t  cmd_o
);
  import rpnc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECODE;
        end
      end

      S_DECODE: begin
        cmd_o.status_set = 1'b1;
        cmd_o.status     = ST_OK;
        state_d          = S_RESP;
        case (stat_i.func)
          FUNC_PUSH: begin
            if (stat_i.cnt_full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.wr_sel  = WR_PUSH;
              cmd_o.top_sel = TOP_OPND;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          FUNC_DROP: begin
            if (stat_i.cnt_zero) begin
              cmd_o.status = ST_FEW;
            end else if (stat_i.cnt_one) begin
              cmd_o.cnt_dec = 1'b1;
            end else begin
              // fetch the new top from the entry below the current one
              cmd_o.rd_sel  = RD_SECOND;
              cmd_o.cnt_dec = 1'b1;
              state_d       = S_DROP_RD;
            end
          end
          FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
            if (stat_i.cnt_lt2) begin
              cmd_o.status = ST_FEW;
            end else if (stat_i.func == FUNC_DIV && stat_i.top_zero) begin
              cmd_o.status = ST_DIVZ;
            end else begin
              cmd_o.rd_sel = RD_SECOND;
              state_d      = S_OP_RD;
            end
          end
          FUNC_MIN: begin
            if (stat_i.cnt_lt2) begin
              cmd_o.status = ST_FEW;
            end else if (stat_i.cnt_full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.acc_sel  = ACC_TOP;
              cmd_o.scan_clr = 1'b1;
              state_d        = S_MIN_RD;
            end
          end
          default: ;
        endcase
      end

      S_DROP_RD: begin
        cmd_o.top_sel = TOP_RDATA;
        state_d       = S_RESP;
      end

      S_OP_RD: begin
        if (stat_i.func == FUNC_DIV) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.acc_sel = ACC_ARITH;
          state_d       = S_WB;
        end
      end

      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_DIV_FIX;
        end
      end

      S_DIV_FIX: begin
        cmd_o.acc_sel = ACC_DIV_FIX;
        state_d       = S_WB;
      end

      S_WB: begin
        cmd_o.wr_sel  = WR_BACK;
        cmd_o.top_sel = TOP_ACC;
        cmd_o.cnt_dec = 1'b1;
        state_d       = S_RESP;
      end

      S_MIN_RD: begin
        cmd_o.rd_sel = RD_SCAN;
        state_d      = S_MIN_CMP;
      end

      S_MIN_CMP: begin
        cmd_o.acc_sel = ACC_MIN;
        if (stat_i.scan_last) begin
          state_d = S_MIN_WR;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_MIN_RD;
        end
      end

      S_MIN_WR: begin
        cmd_o.wr_sel  = WR_MIN;
        cmd_o.top_sel = TOP_ACC;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/rpnc_dp.sv @@
`timescale 1ns / 1ps

module rpnc_dp #(
  parameter int unsigned STACK_DEPTH = rpnc_pkg::RPNC_STACK_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rpnc_pkg::cmd_t                     cmd_i,
  output rpnc_pkg::stat_t                    stat_o,
  input  logic [rpnc_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [rpnc_pkg::DATA_W-1:0] operand_i,
  output logic [rpnc_pkg::STATUS_W-1:0]      status_o,
  output logic signed [rpnc_pkg::DATA_W-1:0] top_value_o,
  output logic [rpnc_pkg::DEPTH_W-1:0]       depth_o
);
  import rpnc_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  func_e             func_q;
  logic [DATA_W-1:0] opnd_q;
  logic [CW-1:0]     cnt_q;
  logic [DATA_W-1:0] top_q;
  logic [DATA_W-1:0] acc_q;
  status_e           status_q;

  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] dvs_q;
  logic              neg_q;
  logic [DIV_CW-1:0] div_cnt_q;
  logic [AW-1:0]     scan_q;

  logic [STATUS_W-1:0] out_status_q;
  logic [DATA_W-1:0]   out_top_q;
  logic [DEPTH_W-1:0]  out_depth_q;

  logic [CW-1:0]     cnt_m2;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] arith;
  logic [DATA_W-1:0] a_abs, b_abs;
  logic [DATA_W:0]   rem_sh, diff;

  assign cnt_m2 = cnt_q - CW'(2);

  // Memory ports
  always_comb begin
    rd_addr = cnt_m2[AW-1:0];
    if (cmd_i.rd_sel == RD_SCAN) begin
      rd_addr = scan_q;
    end
    wr_en   = 1'b1;
    wr_addr = cnt_q[AW-1:0];
    wr_data = acc_q;
    case (cmd_i.wr_sel)
      WR_PUSH: wr_data = opnd_q;
      WR_BACK: wr_addr = cnt_m2[AW-1:0];
      WR_MIN:  ;
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_sel != RD_NONE) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Second entry in rdata_q, top entry in top_q
  always_comb begin
    case (func_q)
      FUNC_SUB: arith = rdata_q - top_q;
      FUNC_MUL: arith = rdata_q * top_q;
      default:  arith = rdata_q + top_q;
    endcase
  end

  assign a_abs  = rdata_q[DATA_W-1] ? (~rdata_q + DATA_W'(1)) : rdata_q;
  assign b_abs  = top_q[DATA_W-1] ? (~top_q + DATA_W'(1)) : top_q;
  assign rem_sh = {rem_q, quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= func_e'(func_i);
      opnd_q <= operand_i;
    end
    if (cmd_i.status_set) begin
      status_q <= cmd_i.status;
    end
    case (cmd_i.top_sel)
      TOP_OPND:  top_q <= opnd_q;
      TOP_RDATA: top_q <= rdata_q;
      TOP_ACC:   top_q <= acc_q;
      default:   ;
    endcase
    case (cmd_i.acc_sel)
      ACC_ARITH:   acc_q <= arith;
      ACC_TOP:     acc_q <= top_q;
      ACC_MIN: begin
        if ($signed(rdata_q) < $signed(acc_q)) begin
          acc_q <= rdata_q;
        end
      end
      ACC_DIV_FIX: acc_q <= neg_q ? (~quo_q + DATA_W'(1)) : quo_q;
      default:     ;
    endcase
    // restoring division on magnitudes, one quotient bit per cycle
    if (cmd_i.div_start) begin
      quo_q <= a_abs;
      dvs_q <= b_abs;
      rem_q <= '0;
      neg_q <= rdata_q[DATA_W-1] ^ top_q[DATA_W-1];
    end else if (cmd_i.div_step) begin
      if (!diff[DATA_W]) begin
        rem_q <= diff[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_top_q    <= (cnt_q == '0) ? '0 : top_q;
      out_depth_q  <= DEPTH_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      div_cnt_q <= '0;
      scan_q    <= '0;
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CW'(1);
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + AW'(1);
      end
    end
  end

  always_comb begin
    stat_o.func      = func_q;
    stat_o.cnt_zero  = (cnt_q == '0);
    stat_o.cnt_one   = (cnt_q == CW'(1));
    stat_o.cnt_lt2   = (cnt_q < CW'(2));
    stat_o.cnt_full  = (cnt_q == CW'(STACK_DEPTH));
    stat_o.top_zero  = (top_q == '0);
    stat_o.div_last  = (div_cnt_q == DIV_CW'(DATA_W - 1));
    stat_o.scan_last = (CW'(scan_q) == cnt_m2);
  end

  assign status_o    = out_status_q;
  assign top_value_o = out_top_q;
  assign depth_o     = out_depth_q;

endmodule

@@ hdl/rpn_stack_calculator.sv @@
`timescale 1ns / 1ps
`include "rpn_stack_calculator_assert.svh"

// Reverse-Polish integer stack calculator. Each command transaction on cmd_i
// (push, drop, add, sub, mul, div, push-minimum) yields exactly one response
// transaction on rsp_o with a status, the new top entry (zero when empty) and
// the new depth. Commands are handled one at a time. Divide takes one quotient
// bit per cycle in the restoring divider, and push-minimum scans the entries
// below the top through the single read port of the stack memory. The next
// command can be accepted once the response is registered, even while it
// waits to be taken. Stack entries live in a one-read, one-write memory; the
// top entry is cached in a register. Reset clears only the control state and
// the counters; the stack memory is not cleared.
module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = rpnc_pkg::RPNC_STACK_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpnc_cmd_if.sink   cmd_i,
  rpnc_rsp_if.source rsp_o
);
  import rpnc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: one command in flight, holds the response until taken
  rpnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Stack memory, count, top cache, ALU, divider and response register
  rpnc_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .func_i      (cmd_i.func),
    .operand_i   (cmd_i.operand),
    .status_o    (rsp_o.status),
    .top_value_o (rsp_o.top_value),
    .depth_o     (rsp_o.depth)
  );

  // A new command is never taken right after one was accepted
  `RPNC_ASSERT_NEXT(a_one_cmd_in_flight, cmd_i.valid && cmd_i.ready, !cmd_i.ready, "second command taken while busy")

  // Writes above the top only happen when there is room
  `RPNC_ASSERT_IMP(a_no_write_when_full, cmd.wr_sel == WR_PUSH || cmd.wr_sel == WR_MIN, !stat.cnt_full, "stack written past its depth")

  // The divider never starts with a zero divisor
  `RPNC_ASSERT_IMP(a_div_nonzero, cmd.div_start, !stat.top_zero, "division started with zero divisor")

  // Only one count update per cycle
  `RPNC_ASSERT_IMP(a_count_one_way, cmd.cnt_inc, !cmd.cnt_dec, "count raised and lowered together")

endmodule

@@ dv/rpn_stack_calculator_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the stack calculator. A short table of commands
// walks the corner cases first: empty stack, single entry, the most negative
// value divided by minus one, divide by zero and the unused code. A long
// random run follows; it switches at random between fill bursts that drive
// the stack to full and mixed traffic that drains it again. Every response
// transaction is compared with the oldest entry of a queue filled as commands
// are accepted, from the in-bench stack model or the hand-typed table rows.
module rpn_stack_calculator_tb;
  import rpnc_pkg::*;

  localparam int unsigned RAND_ITEMS  = 1650;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_AT     = 300;   // accepted commands before the long hold-off
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_FROM  = 700;   // random items run without idling here
  localparam int unsigned QUIET_TO    = 1000;
  localparam int unsigned DRAIN_WAIT  = 64;    // above the slowest command (divide)

  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] top;
    logic [DEPTH_W-1:0]       depth;
  } calc_rsp_t;

  // One row of the directed table. Rows with typed set carry the response
  // written out by hand; the others are predicted.
  typedef struct packed {
    func_e                    func;
    logic signed [DATA_W-1:0] opnd;
    bit                       typed;
    status_e                  status;
    logic signed [DATA_W-1:0] top;
    logic [DEPTH_W-1:0]       depth;
  } dir_row_t;

  localparam int DIR_ROWS = 26;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // Operations on an empty stack.
    '{FUNC_DROP, 32'sd0,        1'b1, ST_FEW,  32'sd0,   5'd0},
    '{FUNC_ADD,  32'sd0,        1'b1, ST_FEW,  32'sd0,   5'd0},
    '{FUNC_MIN,  32'sd0,        1'b1, ST_FEW,  32'sd0,   5'd0},
    '{FUNC_DIV,  32'sd0,        1'b1, ST_FEW,  32'sd0,   5'd0},
    // Single entry: binary ops and minimum need two.
    '{FUNC_PUSH, S32_MIN,       1'b1, ST_OK,   S32_MIN,  5'd1},
    '{FUNC_SUB,  32'sd0,        1'b1, ST_FEW,  S32_MIN,  5'd1},
    '{FUNC_MIN,  32'sd0,        1'b1, ST_FEW,  S32_MIN,  5'd1},
    // Most negative value over minus one wraps back to itself.
    '{FUNC_PUSH, -32'sd1,       1'b1, ST_OK,   -32'sd1,  5'd2},
    '{FUNC_DIV,  32'sd0,        1'b1, ST_OK,   S32_MIN,  5'd1},
    // Divide by zero leaves the stack alone.
    '{FUNC_PUSH, 32'sd0,        1'b1, ST_OK,   32'sd0,   5'd2},
    '{FUNC_DIV,  32'sd0,        1'b1, ST_DIVZ, 32'sd0,   5'd2},
    // Unused code: no change, status ok.
    '{FUNC_NONE, 32'h5A5A_5A5A, 1'b1, ST_OK,   32'sd0,   5'd2},
    '{FUNC_MUL,  32'sd0,        1'b0, ST_OK,   32'sd0,   5'd0},
    '{FUNC_PUSH, S32_MAX,       1'b1, ST_OK,   S32_MAX,  5'd2},
    '{FUNC_ADD,  32'sd0,        1'b0, ST_OK,   32'sd0,   5'd0},
    // Overflow of the sum wraps at 32 bits.
    '{FUNC_PUSH, 32'sd1,        1'b0, ST_OK,   32'sd0,   5'd0},
    '{FUNC_ADD,  32'sd0,        1'b0, ST_OK,   32'sd0,   5'd0},
    '{FUNC_PUSH, S32_MAX,       1'b0, ST_OK,   32'sd0,   5'd0},
    '{FUNC_MIN,  32'sd0,        1'b0, ST_OK,   32'sd0,   5'd0},
    '{FUNC_PUSH, -32'sd7,       1'b0, ST_OK,   32'sd0,   5'd0},
    '{FUNC_MUL,  32'sd0,        1'b0, ST_OK,   32'sd0,   5'd0},
    '{FUNC_SUB,  32'sd0,        1'b0, ST_OK,   32'sd0,   5'd0},
    // Negative quotient truncates toward zero.
    '{FUNC_PUSH, 32'sd3,        1'b0, ST_OK,   32'sd0,   5'd0},
    '{FUNC_DIV,  32'sd0,        1'b0, ST_OK,   32'sd0,   5'd0},
    '{FUNC_DROP, 32'sd0,        1'b0, ST_OK,   32'sd0,   5'd0},
    '{FUNC_DROP, 32'sd0,        1'b0, ST_OK,   32'sd0,   5'd0}
  };

  logic clk_i;
  logic rst_ni;

  rpnc_cmd_if cmd_if ();
  rpnc_rsp_if rsp_if ();

  rpn_stack_calculator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  // Stack model and the responses it still owes.
  logic signed [DATA_W-1:0] model_mem [RPNC_STACK_DEPTH];
  int unsigned              model_cnt;
  calc_rsp_t                rsp_expect_q [$];

  int unsigned accepted_cnt;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          quiet_phase;

  // Clock: 8 ns period.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Append one expected response to the queue.
  function automatic void expect_add(calc_rsp_t r);
    rsp_expect_q = {rsp_expect_q, r};
  endfunction

  // Apply one command to the stack model and return the response it causes.
  function automatic calc_rsp_t stack_apply(func_e f, logic signed [DATA_W-1:0] opnd);
    calc_rsp_t                res;
    logic signed [DATA_W-1:0] lhs;
    logic signed [DATA_W-1:0] rhs;
    logic signed [DATA_W-1:0] acc;
    longint                   quo;
    res.status = ST_OK;
    case (f)
      FUNC_PUSH: begin
        if (model_cnt >= RPNC_STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          model_mem[model_cnt] = opnd;
          model_cnt++;
        end
      end
      FUNC_DROP: begin
        if (model_cnt == 0) res.status = ST_FEW;
        else model_cnt--;
      end
      FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
        if (model_cnt < 2) begin
          res.status = ST_FEW;
        end else begin
          lhs = model_mem[model_cnt-2];
          rhs = model_mem[model_cnt-1];
          if (f == FUNC_DIV && rhs == 0) begin
            res.status = ST_DIVZ;
          end else begin
            case (f)
              FUNC_ADD: acc = lhs + rhs;
              FUNC_SUB: acc = lhs - rhs;
              FUNC_MUL: acc = lhs * rhs;
              default: begin
                // Widen first so the most negative value over minus one wraps.
                quo = longint'(lhs) / longint'(rhs);
                acc = quo[DATA_W-1:0];
              end
            endcase
            model_cnt--;
            model_mem[model_cnt-1] = acc;
          end
        end
      end
      FUNC_MIN: begin
        if (model_cnt < 2) begin
          res.status = ST_FEW;
        end else if (model_cnt >= RPNC_STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          acc = S32_MAX;
          for (int unsigned i = 0; i < model_cnt; i++) begin
            if (model_mem[i] < acc) acc = model_mem[i];
          end
          model_mem[model_cnt] = acc;
          model_cnt++;
        end
      end
      default: ;
    endcase
    res.top   = (model_cnt != 0) ? model_mem[model_cnt-1] : '0;
    res.depth = DEPTH_W'(model_cnt);
    return res;
  endfunction

  // Offer one command from the next falling edge and return at the rising
  // edge that takes it. Idle cycles drop valid before the offer.
  task automatic offer_cmd(func_e f, logic signed [DATA_W-1:0] opnd);
    @(negedge clk_i);
    while (!quiet_phase && $urandom_range(0, 99) < 16) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.func    <= f;
    cmd_if.operand <= opnd;
    do @(posedge clk_i); while (!cmd_if.ready);
    accepted_cnt++;
  endtask

  // Pick an operand: full random, near zero (feeds divide by zero), or an extreme.
  function automatic logic signed [DATA_W-1:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 7) return $signed($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 4))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return 32'sd1;
    endcase
  endfunction

  // Command source: reset, directed table, then random traffic.
  initial begin : cmd_source
    dir_row_t    row;
    calc_rsp_t   pred;
    calc_rsp_t   typed_rsp;
    func_e       f;
    bit          fill_burst;
    int unsigned roll;
    logic signed [DATA_W-1:0] opnd;

    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.func    = FUNC_PUSH;
    cmd_if.operand = '0;
    quiet_phase    = 1'b0;
    accepted_cnt   = 0;
    fill_burst     = 1'b0;
    model_cnt      = 0;
    foreach (model_mem[i]) model_mem[i] = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; hand-typed rows still advance the model.
    for (int n = 0; n < DIR_ROWS; n++) begin
      row = dir_tab[n];
      offer_cmd(row.func, row.opnd);
      pred = stack_apply(row.func, row.opnd);
      if (row.typed) begin
        typed_rsp.status = row.status;
        typed_rsp.top    = row.top;
        typed_rsp.depth  = row.depth;
        expect_add(typed_rsp);
      end else begin
        expect_add(pred);
      end
    end

    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      quiet_phase = (n >= QUIET_FROM && n < QUIET_TO);
      // Pick fill bursts or mixed traffic anew every 48 commands.
      if (n % 48 == 0) fill_burst = ($urandom_range(0, 2) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        f = func_e'($urandom_range(0, 7));
      end else if (roll < (fill_burst ? 75 : 45)) begin
        f = FUNC_PUSH;
      end else begin
        case ($urandom_range(0, 12))
          0, 1:    f = FUNC_DROP;
          2, 3:    f = FUNC_ADD;
          4, 5:    f = FUNC_SUB;
          6, 7:    f = FUNC_MUL;
          8, 9:    f = FUNC_DIV;
          10, 11:  f = FUNC_MIN;
          default: f = FUNC_NONE;
        endcase
      end
      opnd = pick_operand();
      offer_cmd(f, opnd);
      expect_add(stack_apply(f, opnd));
    end
    quiet_phase = 1'b0;

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;

    // Drain, then wait out the slowest command to catch stray responses.
    while (rsp_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("rpn_stack_calculator_tb OK");
    end else begin
      $display("rpn_stack_calculator_tb NOT OK");
    end
    $finish;
  end

  // Response sink: random back-pressure, one long hold-off so the block
  // fills and stalls its command input.
  initial begin : rsp_sink
    int unsigned hold_left;
    bit          hold_done;
    rsp_if.ready = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= quiet_phase || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  // Compare each response transaction against the oldest expectation.
  initial mismatch_cnt = 0;

  always @(posedge clk_i) begin
    calc_rsp_t exp_rsp;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (rsp_expect_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected response: status %0d top %0d depth %0d", $time,
                 rsp_if.status, rsp_if.top_value, rsp_if.depth);
      end else begin
        exp_rsp = rsp_expect_q.pop_front();
        if (rsp_if.status !== exp_rsp.status) begin
          mismatch_cnt++;
          $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                   rsp_if.status);
        end
        if (rsp_if.top_value !== exp_rsp.top) begin
          mismatch_cnt++;
          $display("%0t: top_value expected %0d actual %0d", $time, exp_rsp.top,
                   rsp_if.top_value);
        end
        if (rsp_if.depth !== exp_rsp.depth) begin
          mismatch_cnt++;
          $display("%0t: depth expected %0d actual %0d", $time, exp_rsp.depth,
                   rsp_if.depth);
        end
      end
    end
  end

  // Watchdog: end a hung run.
  initial cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("rpn_stack_calculator_tb NOT OK");
      $finish;
    end
  end

endmodule
